/* rtl/direct_mapped_hash_table_top_assert.svh */
// assertion macros for the direct-mapped hash table
`ifndef DIRECT_MAPPED_HASH_TABLE_TOP_ASSERT_SVH
`define DIRECT_MAPPED_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dht_pkg.sv */
// shared constants, codes and controller/datapath interface types
`default_nettype none
package dht_pkg;

  localparam int MAX_BUCKETS  = 1024;
  localparam int INIT_BUCKETS = (16 > MAX_BUCKETS) ? MAX_BUCKETS : 16;
  localparam int HASH_W       = 32;
  localparam int VALUE_W      = 32;
  localparam int SLOT_W       = $clog2(MAX_BUCKETS);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int WORD_W       = 1 + HASH_W + VALUE_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_ERASED    = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_CLR, S_G_RD, S_G_CHK, S_G_MV, S_G_KILL, S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE, RD_SLOT, RD_IDX
  } rd_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_NEW, WR_KILL_SLOT, WR_KILL_IDX, WR_MOVE
  } wr_op_t;

  typedef struct packed {
    logic    load;
    rd_op_t  rd;
    wr_op_t  wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    bt_double;
    logic    res_ld;
    status_t res_status;
  } dht_cmd_t;

  typedef struct packed {
    action_t action;
    logic    hit;
    logic    occupied;
    logic    at_max;
    logic    move;
    logic    idx_last_bt;
    logic    idx_last_max;
    logic    out_free;
  } dht_sts_t;

endpackage
`default_nettype wire

/* rtl/dht_ctrl.sv */
// controller state machine: sequences lookups, sweeps and rehash passes
`default_nettype none
module dht_ctrl
  import dht_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  var  dht_sts_t sts,
  output dht_cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      status_r <= ST_NOT_FOUND;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.rd     = RD_NONE;
    cmd.wr     = WR_NONE;
    cmd.res_status = status_r;
    in_tready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.wr      = WR_KILL_IDX;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last_max) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.action == ACT_CLEAR) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          cmd.rd    = RD_SLOT;
          state_nxt = S_CHK;
        end
      end
      S_CLR: begin
        cmd.wr      = WR_KILL_IDX;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last_bt) begin
          cmd.idx_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
          status_nxt  = ST_CLEARED;
          state_nxt   = S_RESP;
        end
      end
      S_CHK: begin
        state_nxt = S_RESP;
        case (sts.action)
          ACT_INSERT: begin
            if (sts.hit) begin
              status_nxt = ST_PRESENT;
            end else if (!sts.occupied) begin
              cmd.wr      = WR_NEW;
              cmd.cnt_inc = 1'b1;
              status_nxt  = ST_INSERTED;
            end else if (sts.at_max) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_G_RD;
            end
          end
          ACT_FIND: begin
            status_nxt = sts.hit ? ST_PRESENT : ST_NOT_FOUND;
          end
          ACT_ERASE: begin
            if (sts.hit) begin
              cmd.wr      = WR_KILL_SLOT;
              cmd.cnt_dec = 1'b1;
              status_nxt  = ST_ERASED;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            status_nxt = ST_CLEARED;
          end
        endcase
      end
      S_G_RD: begin
        cmd.rd    = RD_IDX;
        state_nxt = S_G_CHK;
      end
      S_G_CHK, S_G_KILL: begin
        if (state_r == S_G_KILL) begin
          cmd.wr = WR_KILL_IDX;
        end
        if (state_r == S_G_CHK && sts.move) begin
          state_nxt = S_G_MV;
        end else if (sts.idx_last_bt) begin
          cmd.bt_double = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_nxt     = S_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_G_RD;
        end
      end
      S_G_MV: begin
        cmd.wr    = WR_MOVE;
        state_nxt = S_G_KILL;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dht_dp.sv */
// datapath: slot memory, request registers, counters and result register
`default_nettype none
`include "direct_mapped_hash_table_top_assert.svh"
module dht_dp
  import dht_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_action,
  input  wire logic [HASH_W-1:0]  in_key,
  input  wire logic [VALUE_W-1:0] in_value,
  input  var  dht_cmd_t           cmd,
  output dht_sts_t                sts,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [2:0]              out_status,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [VALUE_W-1:0]      out_value,
  output logic [CNT_W-1:0]        out_entries,
  output logic [CNT_W-1:0]        out_buckets
);

  logic [WORD_W-1:0]  mem [MAX_BUCKETS];
  logic [WORD_W-1:0]  rdata_r;
  action_t            action_r;
  logic [HASH_W-1:0]  key_r;
  logic [VALUE_W-1:0] value_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   bt_r;
  logic               out_valid_r;
  status_t            res_status_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [VALUE_W-1:0] res_value_r;
  logic [CNT_W-1:0]   res_cnt_r;
  logic [CNT_W-1:0]   res_bt_r;

  logic [CNT_W-1:0]   bt_m1;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  dst;
  logic               rd_valid;
  logic [HASH_W-1:0]  rd_hash;
  logic [VALUE_W-1:0] rd_value;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [SLOT_W-1:0]  rd_addr;

  // bucket count is a power of two, so the modulo is a mask
  assign bt_m1    = bt_r - CNT_W'(1);
  assign slot     = key_r[SLOT_W-1:0] & bt_m1[SLOT_W-1:0];
  assign dst      = idx_r + bt_r[SLOT_W-1:0];
  assign rd_valid = rdata_r[WORD_W-1];
  assign rd_hash  = rdata_r[HASH_W+VALUE_W-1:VALUE_W];
  assign rd_value = rdata_r[VALUE_W-1:0];

  assign sts.action       = action_r;
  assign sts.occupied     = rd_valid;
  assign sts.hit          = rd_valid && (rd_hash == key_r);
  assign sts.at_max       = bt_r > CNT_W'(MAX_BUCKETS / 2);
  assign sts.move         = rd_valid && ((rd_hash[CNT_W-1:0] & bt_r) != '0);
  assign sts.idx_last_bt  = {1'b0, idx_r} == bt_m1;
  assign sts.idx_last_max = idx_r == SLOT_W'(MAX_BUCKETS - 1);
  assign sts.out_free     = !out_valid_r || out_tready;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r;
    wr_data = '0;
    case (cmd.wr)
      WR_NEW: begin
        wr_addr = slot;
        wr_data = {1'b1, key_r, value_r};
      end
      WR_KILL_SLOT: wr_addr = slot;
      WR_KILL_IDX:  wr_addr = idx_r;
      WR_MOVE: begin
        wr_addr = dst;
        wr_data = rdata_r;
      end
      default: wr_en = 1'b0;
    endcase
    rd_addr = (cmd.rd == RD_SLOT) ? slot : idx_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd != RD_NONE) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action_t'(in_action);
      key_r    <= in_key;
      value_r  <= in_value;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= (cmd.res_status == ST_CLEARED) ? '0 : slot;
      res_value_r  <= (cmd.res_status == ST_PRESENT) ? rd_value : '0;
      res_cnt_r    <= cnt_r;
      res_bt_r     <= bt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      bt_r        <= CNT_W'(INIT_BUCKETS);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.bt_double) begin
        bt_r <= {bt_r[CNT_W-2:0], 1'b0};
      end
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_status  = res_status_r;
  assign out_slot    = res_slot_r;
  assign out_value   = res_value_r;
  assign out_entries = res_cnt_r;
  assign out_buckets = res_bt_r;

  `DHT_ASSERT_IMP(a_bt_pow2, 1'b1, $onehot(bt_r), "bucket count not a power of two")
  `DHT_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CNT_W'(MAX_BUCKETS), "entry count above max")
  `DHT_ASSERT_NXT(a_bt_dbl, cmd.bt_double, bt_r == {$past(bt_r[CNT_W-2:0]), 1'b0}, "bad doubling")
  `DHT_ASSERT_NXT(a_res_ld, cmd.res_ld, out_valid_r, "result load lost")

endmodule
`default_nettype wire

/* rtl/direct_mapped_hash_table_top.sv */
// top level of the direct-mapped hash table with doubling rehash
//
// input stream: in_tuser carries the operation (insert, find, erase, clear),
//   in_tdata carries the key hash and the value word for an insert
// result stream: one request in gives exactly one result out, with status in
//   out_tuser and slot, value, entry count and bucket count in out_tdata
// after reset the slot memory is swept clean, one slot a cycle, all 1024
//   slots; in_tready stays low during the sweep
// find, erase and a simple insert: after accept the controller steps through
//   the read, check and response states, then takes the next request
// clear walks the current buckets, one slot a cycle, then zeroes the entry
//   count and goes to the response state
// an insert that collides rehashes, or reports full at 1024 buckets: each
//   doubling pass walks all old slots through the single memory read port,
//   moves each slot whose new hash bit is set, then retries the lookup
// one request is worked on at a time; the next is taken as soon as the
//   result sits in the output register, even while out_tready is low
// a stalled receiver holds the result register; a new result is not
//   written until the previous one has been taken
`default_nettype none
module direct_mapped_hash_table_top
  import dht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key_hash [31:0], value_in [63:32]
  input  wire logic [1:0]  in_tuser,   // action [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // slot_index [9:0], value_out [41:10],
                                       // entries_held [52:42], buckets_in_use [63:53]
  output logic [2:0]       out_tuser   // status [2:0]
);

  dht_cmd_t           cmd;
  dht_sts_t           sts;
  logic [2:0]         res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [VALUE_W-1:0] res_value;
  logic [CNT_W-1:0]   res_entries;
  logic [CNT_W-1:0]   res_buckets;

  // sequencer
  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot memory and counters
  dht_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_value    (in_tdata[63:32]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (res_status),
    .out_slot    (res_slot),
    .out_value   (res_value),
    .out_entries (res_entries),
    .out_buckets (res_buckets)
  );

  // pack result fields, lowest first
  assign out_tdata = {res_buckets, res_entries, res_value, res_slot};
  assign out_tuser = res_status;

endmodule
`default_nettype wire
